### sv/ps2_set2_scancode_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// ps2_set2_scancode_decoder_top_macros.svh
// Assertion macros shared by the scan code decoder RTL.
// ----------------------------------------------------------------------------
`ifndef PS2_SET2_SCANCODE_DECODER_TOP_MACROS_SVH
`define PS2_SET2_SCANCODE_DECODER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PS2_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ps2 decoder: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define PS2_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ps2 decoder: next-cycle check failed");

`endif

### sv/ps2dec_pkg.sv
// ----------------------------------------------------------------------------
// ps2dec_pkg
// Types, prefix codes and scan code set 2 lookup tables for the decoder.
// ----------------------------------------------------------------------------
package ps2dec_pkg;

	localparam logic [7:0] ExtPrefix   = 8'hE0;
	localparam logic [7:0] BreakPrefix = 8'hF0;
	localparam logic [7:0] NullByte    = 8'h00;
	localparam logic [6:0] KeyNone     = 7'd0;

	typedef struct packed {
		logic ext;
		logic rel;
	} flags_t;

	typedef struct packed {
		logic       res_valid;
		logic       key_down;
		logic [6:0] key_code;
		flags_t     flags_next;
	} dec_res_t;

	function automatic logic [6:0] normal_lookup(input logic [7:0] b);
		logic [6:0] k;
		case (b)
			8'h76: k = 7'd1;
			8'h05: k = 7'd2;
			8'h06: k = 7'd3;
			8'h04: k = 7'd4;
			8'h0C: k = 7'd5;
			8'h03: k = 7'd6;
			8'h0B: k = 7'd7;
			8'h83: k = 7'd8;
			8'h0A: k = 7'd9;
			8'h01: k = 7'd10;
			8'h09: k = 7'd11;
			8'h78: k = 7'd12;
			8'h07: k = 7'd13;
			8'h0E: k = 7'd14;
			8'h16: k = 7'd15;
			8'h1E: k = 7'd16;
			8'h26: k = 7'd17;
			8'h25: k = 7'd18;
			8'h2E: k = 7'd19;
			8'h36: k = 7'd20;
			8'h3D: k = 7'd21;
			8'h3E: k = 7'd22;
			8'h46: k = 7'd23;
			8'h45: k = 7'd24;
			8'h4E: k = 7'd25;
			8'h55: k = 7'd26;
			8'h66: k = 7'd27;
			8'h0D: k = 7'd28;
			8'h15: k = 7'd29;
			8'h1D: k = 7'd30;
			8'h24: k = 7'd31;
			8'h2D: k = 7'd32;
			8'h2C: k = 7'd33;
			8'h35: k = 7'd34;
			8'h3C: k = 7'd35;
			8'h43: k = 7'd36;
			8'h44: k = 7'd37;
			8'h4D: k = 7'd38;
			8'h54: k = 7'd39;
			8'h5B: k = 7'd40;
			8'h5D: k = 7'd41;
			8'h58: k = 7'd42;
			8'h1C: k = 7'd43;
			8'h1B: k = 7'd44;
			8'h23: k = 7'd45;
			8'h2B: k = 7'd46;
			8'h34: k = 7'd47;
			8'h33: k = 7'd48;
			8'h3B: k = 7'd49;
			8'h42: k = 7'd50;
			8'h4B: k = 7'd51;
			8'h4C: k = 7'd52;
			8'h52: k = 7'd53;
			8'h5A: k = 7'd54;
			8'h12: k = 7'd55;
			8'h1A: k = 7'd56;
			8'h22: k = 7'd57;
			8'h21: k = 7'd58;
			8'h2A: k = 7'd59;
			8'h32: k = 7'd60;
			8'h31: k = 7'd61;
			8'h3A: k = 7'd62;
			8'h41: k = 7'd63;
			8'h49: k = 7'd64;
			8'h4A: k = 7'd65;
			8'h59: k = 7'd66;
			8'h14: k = 7'd67;
			8'h11: k = 7'd69;
			8'h29: k = 7'd70;
			default: k = KeyNone;
		endcase
		return k;
	endfunction

	function automatic logic [6:0] extended_lookup(input logic [7:0] b);
		logic [6:0] k;
		case (b)
			8'h2F: k = 7'd68;
			8'h11: k = 7'd71;
			8'h14: k = 7'd72;
			8'h75: k = 7'd73;
			8'h72: k = 7'd74;
			8'h6B: k = 7'd75;
			8'h74: k = 7'd76;
			8'h70: k = 7'd77;
			8'h71: k = 7'd78;
			8'h6C: k = 7'd79;
			8'h69: k = 7'd80;
			8'h7D: k = 7'd81;
			8'h7A: k = 7'd82;
			default: k = KeyNone;
		endcase
		return k;
	endfunction

endpackage

### sv/ps2dec_decode.sv
// ----------------------------------------------------------------------------
// ps2dec_decode
// Prefix tracking and table lookup for one scan byte, given the pending flags.
// ----------------------------------------------------------------------------
module ps2dec_decode (
	input  logic [7:0]          scan_byte,
	input  ps2dec_pkg::flags_t  flags,
	output ps2dec_pkg::dec_res_t res
);
	import ps2dec_pkg::*;

	always_comb begin
		res.res_valid  = 1'b1;
		res.key_down   = 1'b0;
		res.key_code   = KeyNone;
		res.flags_next = '0;
		if (scan_byte == ExtPrefix && !flags.ext && !flags.rel) begin
			res.res_valid      = 1'b0;
			res.flags_next.ext = 1'b1;
		end else if (scan_byte == BreakPrefix && !flags.rel) begin
			res.res_valid      = 1'b0;
			res.flags_next.ext = flags.ext;
			res.flags_next.rel = 1'b1;
		end else if (scan_byte == NullByte && !flags.ext && !flags.rel) begin
			res.key_down = 1'b0;
			res.key_code = KeyNone;
		end else begin
			res.key_down = !flags.rel;
			res.key_code = flags.ext ? extended_lookup(scan_byte) : normal_lookup(scan_byte);
		end
	end

endmodule

### sv/ps2_set2_scancode_decoder_top.sv
// ----------------------------------------------------------------------------
// ps2_set2_scancode_decoder_top
// PS/2 scan code set 2 byte decoder with prefix tracking and result register.
// ----------------------------------------------------------------------------
// Accepts one keyboard byte per clock cycle while in_stall is low and returns
// at most one key event per byte; a prefix byte (E0 extended, F0 break) that
// sets its flag produces no event. A byte is captured in the input register,
// decoded against the pending prefix flags by a single table lookup, and lands
// in the result register when it advances. The lookup sits between those two
// registers; a stalled result holds its register, and a new byte is still
// taken while the decode of the held byte needs no result slot or the result
// register drains.
module ps2_set2_scancode_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       key_down,
	output logic [6:0] key_code
);
	import ps2dec_pkg::*;
	`include "ps2_set2_scancode_decoder_top_macros.svh"

	logic       valid_s1;
	logic [7:0] byte_s1;
	flags_t     flags_q;
	dec_res_t   dec;
	logic       valid_s2;
	logic       key_down_s2;
	logic [6:0] key_code_s2;
	logic       adv_s1;
	logic       slot_free;

	ps2dec_decode u_decode (
		.scan_byte (byte_s1),
		.flags     (flags_q),
		.res       (dec)
	);

	assign slot_free = !valid_s2 || !out_stall;
	assign adv_s1    = valid_s1 && (!dec.res_valid || slot_free);
	assign in_stall  = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flags_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				flags_q <= dec.flags_next;
			end
			if (slot_free) begin
				valid_s2 <= adv_s1 && dec.res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= scan_byte;
		end
		if (slot_free && adv_s1 && dec.res_valid) begin
			key_down_s2 <= dec.key_down;
			key_code_s2 <= dec.key_code;
		end
	end

	assign out_valid = valid_s2;
	assign key_down  = key_down_s2;
	assign key_code  = key_code_s2;

	`PS2_ASSERT_NEXT(a_prefix_sets_flag, adv_s1 && !dec.res_valid, flags_q.ext || flags_q.rel)
	`PS2_ASSERT_NEXT(a_event_clears_flags, adv_s1 && dec.res_valid,
		valid_s2 && !flags_q.ext && !flags_q.rel)
	`PS2_ASSERT_SAME(a_stall_needs_full_slot, in_stall, valid_s2 && out_stall && dec.res_valid)

endmodule

### tb/tb_ps2_set2_scancode_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_ps2_set2_scancode_decoder_top
// Self-checking bench for the PS/2 set 2 scan code decoder.
// ----------------------------------------------------------------------------
// Feeds keyboard bytes through the input channel and predicts every key event
// from its own key tables and prefix flags. Each event taken from the output
// channel is checked against the oldest one still due. Directed bytes cover
// the byte extremes and the prefix corner cases. Random traffic mixes
// well-formed make and break strokes with stray bytes and broken prefix runs,
// under changing idle patterns on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_ps2_set2_scancode_decoder_top;
	import ps2dec_pkg::*;

	localparam int StallLimit   = 3000;
	localparam int HoldCycles   = 300;
	localparam int AppsKey      = 68;
	localparam int LastPlainKey = 70;
	localparam int NumKeys      = 82;

	localparam logic [7:0] ScanEscape   = 8'h76;
	localparam logic [7:0] ScanF7       = 8'h83;
	localparam logic [7:0] ScanAllOnes  = 8'hFF;
	localparam logic [7:0] ScanPageDown = 8'h7A;
	localparam logic [7:0] ScanApps     = 8'h2F;
	localparam logic [7:0] ScanCtrl     = 8'h14;
	localparam logic [7:0] ScanAlt      = 8'h11;

	typedef struct packed {
		logic       key_down;
		logic [6:0] key_code;
	} key_event_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] scan_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       key_down;
	logic [6:0] key_code;

	logic [7:0] scan_of_key [1:NumKeys];
	logic [6:0] plain_keymap [256];
	logic [6:0] ext_keymap [256];
	logic [7:0] plain_scans [$];
	logic [7:0] ext_scans [$];
	key_event_t key_events_due [$];

	logic ext_pending = 1'b0;
	logic rel_pending = 1'b0;
	logic hold_req    = 1'b0;
	logic hold_armed  = 1'b0;
	int   hold_left     = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   items_sent    = 0;
	int   err_count     = 0;
	int   stall_cycles  = 0;

	ps2_set2_scancode_decoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.scan_byte (scan_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.key_down  (key_down),
		.key_code  (key_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin : build_keymaps
		int k;
		scan_of_key = '{
			8'h76, 8'h05, 8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83, 8'h0A, 8'h01,
			8'h09, 8'h78, 8'h07, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36,
			8'h3D, 8'h3E, 8'h46, 8'h45, 8'h4E, 8'h55, 8'h66, 8'h0D, 8'h15, 8'h1D,
			8'h24, 8'h2D, 8'h2C, 8'h35, 8'h3C, 8'h43, 8'h44, 8'h4D, 8'h54, 8'h5B,
			8'h5D, 8'h58, 8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h34, 8'h33, 8'h3B, 8'h42,
			8'h4B, 8'h4C, 8'h52, 8'h5A, 8'h12, 8'h1A, 8'h22, 8'h21, 8'h2A, 8'h32,
			8'h31, 8'h3A, 8'h41, 8'h49, 8'h4A, 8'h59, 8'h14, 8'h2F, 8'h11, 8'h29,
			8'h11, 8'h14, 8'h75, 8'h72, 8'h6B, 8'h74, 8'h70, 8'h71, 8'h6C, 8'h69,
			8'h7D, 8'h7A
		};
		foreach (plain_keymap[i]) begin
			plain_keymap[i] = KeyNone;
			ext_keymap[i]   = KeyNone;
		end
		for (k = 1; k <= NumKeys; k++) begin
			if (k == AppsKey || k > LastPlainKey) begin
				ext_keymap[scan_of_key[k]] = 7'(k);
				ext_scans.push_back(scan_of_key[k]);
			end else begin
				plain_keymap[scan_of_key[k]] = 7'(k);
				plain_scans.push_back(scan_of_key[k]);
			end
		end
	end

	function automatic void predict_key_event(input logic [7:0] b);
		logic [6:0] code;
		if (b == ExtPrefix && !ext_pending && !rel_pending) begin
			ext_pending = 1'b1;
		end else if (b == BreakPrefix && !rel_pending) begin
			rel_pending = 1'b1;
		end else if (b == NullByte && !ext_pending && !rel_pending) begin
			key_events_due.push_back(key_event_t'{key_down: 1'b0, key_code: KeyNone});
		end else begin
			code = ext_pending ? ext_keymap[b] : plain_keymap[b];
			key_events_due.push_back(key_event_t'{key_down: !rel_pending, key_code: code});
			ext_pending = 1'b0;
			rel_pending = 1'b0;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		scan_byte <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_key_event(b);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (key_events_due.size() != 0);
	endtask

	task automatic send_key_stroke();
		logic       ext;
		logic [7:0] code;
		ext  = ($urandom_range(3) == 0);
		code = ext ? ext_scans[$urandom_range(ext_scans.size() - 1)]
			: plain_scans[$urandom_range(plain_scans.size() - 1)];
		if (ext)
			send_byte(ExtPrefix);
		if ($urandom_range(1))
			send_byte(BreakPrefix);
		send_byte(code);
	endtask

	task automatic send_noise();
		case ($urandom_range(4))
			0: send_byte(8'($urandom_range(255)));
			1: send_byte(NullByte);
			2: begin
				send_byte($urandom_range(1) ? ExtPrefix : BreakPrefix);
				send_byte(8'($urandom_range(255)));
			end
			3: begin
				send_byte(ExtPrefix);
				send_byte(BreakPrefix);
				send_byte($urandom_range(1) ? ExtPrefix : BreakPrefix);
			end
			default: send_byte($urandom_range(1) ? ExtPrefix : BreakPrefix);
		endcase
	endtask

	task automatic send_traffic();
		if ($urandom_range(99) < 70)
			send_key_stroke();
		else
			send_noise();
	endtask

	task automatic test_byte_extremes();
		send_byte(NullByte);
		send_byte(ScanAllOnes);
		send_byte(ScanEscape);
		send_byte(ScanF7);
		wait_drained();
	endtask

	task automatic test_prefix_rules();
		send_byte(ExtPrefix);
		send_byte(ScanPageDown);
		send_byte(ExtPrefix);
		send_byte(BreakPrefix);
		send_byte(ScanApps);
		send_byte(BreakPrefix);
		send_byte(ScanCtrl);
		send_byte(ExtPrefix);
		send_byte(ScanAlt);
		send_byte(ScanAlt);
		send_byte(BreakPrefix);
		send_byte(BreakPrefix);
		send_byte(ExtPrefix);
		send_byte(ExtPrefix);
		send_byte(BreakPrefix);
		send_byte(ExtPrefix);
		send_byte(ExtPrefix);
		send_byte(BreakPrefix);
		send_byte(ExtPrefix);
		send_byte(ExtPrefix);
		send_byte(NullByte);
		send_byte(BreakPrefix);
		send_byte(NullByte);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
		int target;
		send_idle_pct = tx_pct;
		recv_idle_pct = rx_pct;
		target = items_sent + n_items;
		while (items_sent < target)
			send_traffic();
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req <= 1'b1;
		repeat (60)
			send_traffic();
		hold_req <= 1'b0;
		wait_drained();
	endtask

	always @(posedge clk) begin : result_check
		key_event_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (key_events_due.size() == 0) begin
				$error("key event down=%0d code=%0d with none due", key_down, key_code);
				err_count++;
			end else begin
				due = key_events_due.pop_front();
				if (key_down !== due.key_down) begin
					$error("key_down: expected %0d, actual %0d", due.key_down, key_down);
					err_count++;
				end
				if (key_code !== due.key_code) begin
					$error("key_code: expected %0d, actual %0d", due.key_code, key_code);
					err_count++;
				end
			end
		end
		if (hold_req && !hold_armed)
			hold_left = HoldCycles;
		hold_armed = hold_req;
		out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
		if (hold_left > 0)
			hold_left--;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= StallLimit) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_byte_extremes();
		test_prefix_rules();
		test_random_traffic(600, 15, 61);
		test_backpressure();
		test_random_traffic(600, 61, 15);
		test_random_traffic(570, 0, 0);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
